[design/pcs_pkg.sv]
package pcs_pkg;

	// Width of the byte position counter unless the top level overrides it.
	localparam int OFFSET_BITS_DEFAULT = 32;

	// Result queue depth; it must hold the two results a single byte can give.
	localparam int RQ_DEPTH = 4;

	localparam logic [63:0] SIG_WORD  = 64'h89504E470D0A1A0A;
	localparam logic [31:0] NAME_IHDR = 32'h49484452;
	localparam logic [31:0] NAME_IDAT = 32'h49444154;
	localparam logic [31:0] NAME_IEND = 32'h49454E44;

	// Positions of the last signature byte and the last IHDR name byte.
	localparam int SIG_LAST_POS  = 7;
	localparam int IHDR_LAST_POS = 15;
	// Distance from the last IDAT name byte back to its length field.
	localparam int NAME_TO_LEN   = 7;

	// Four-byte window and CRC count.
	localparam logic [2:0] WORD_BYTES = 3'd4;

	localparam logic [2:0] EV_SIG_OK       = 3'd0;
	localparam logic [2:0] EV_SIG_BAD      = 3'd1;
	localparam logic [2:0] EV_IHDR_OK      = 3'd2;
	localparam logic [2:0] EV_IHDR_MISSING = 3'd3;
	localparam logic [2:0] EV_IDAT         = 3'd4;
	localparam logic [2:0] EV_IEND_OK      = 3'd5;
	localparam logic [2:0] EV_IEND_MISSING = 3'd6;

	typedef enum logic [2:0] {
		PH_SIG,
		PH_IHDR,
		PH_IHDR_SKIP,
		PH_IHDR_CRC,
		PH_SEARCH,
		PH_IDAT_SKIP,
		PH_IDAT_CRC,
		PH_FAILED
	} phase_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_file;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  event_kind;
		logic [31:0] chunk_offset;
		logic [31:0] chunk_length;
		logic [31:0] chunk_crc;
		logic        last_of_run;
	} out_item_t;

	// Results produced by one byte: an optional structural event, then an
	// optional end-of-file event.
	typedef struct packed {
		logic      valid0;
		out_item_t r0;
		logic      valid1;
		out_item_t r1;
	} pcs_emit_t;

endpackage

[design/pcs_parser.sv]
module pcs_parser import pcs_pkg::*; #(
	parameter int OFFSET_BITS = OFFSET_BITS_DEFAULT
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      take,
	input  in_item_t  item,
	output pcs_emit_t emit
);

	phase_t                 phase_q, phase_mid, phase_d;
	logic [OFFSET_BITS-1:0] pos_q, pos_d, off_full;
	logic [63:0]            recent_q, win;
	logic [31:0]            skip_q, skip_d, skip_dec;
	logic [2:0]             cnt_q, cnt_d, cnt_inc, cnt_srch;
	logic [31:0]            foff_q, foff_d;
	logic [31:0]            flen_q, flen_d;
	logic [31:0]            crc_q, crc_d, crc_shift;
	logic                   at_sig_end, at_ihdr_end, sig_match, ihdr_match;
	logic                   idat_match, crc_done;

	assign win         = {recent_q[55:0], item.data_byte};
	assign skip_dec    = skip_q - 32'd1;
	assign cnt_inc     = cnt_q + 3'd1;
	assign cnt_srch    = (cnt_q < WORD_BYTES) ? cnt_inc : cnt_q;
	assign crc_shift   = {crc_q[23:0], item.data_byte};
	assign off_full    = pos_q - OFFSET_BITS'(NAME_TO_LEN);
	assign at_sig_end  = pos_q == OFFSET_BITS'(SIG_LAST_POS);
	assign at_ihdr_end = pos_q == OFFSET_BITS'(IHDR_LAST_POS);
	assign sig_match   = win == SIG_WORD;
	assign ihdr_match  = win[31:0] == NAME_IHDR;
	assign idat_match  = (cnt_srch >= WORD_BYTES) && (win[31:0] == NAME_IDAT);
	assign crc_done    = cnt_inc >= WORD_BYTES;

	// Next phase, before and after the end-of-file restart.
	always_comb begin
		phase_mid = phase_q;
		unique case (phase_q)
			PH_SIG: begin
				if (at_sig_end) begin
					phase_mid = sig_match ? PH_IHDR : PH_FAILED;
				end
			end
			PH_IHDR: begin
				if (at_ihdr_end) begin
					if (!ihdr_match) begin
						phase_mid = PH_FAILED;
					end else begin
						phase_mid = (win[63:32] != 32'd0) ? PH_IHDR_SKIP : PH_IHDR_CRC;
					end
				end
			end
			PH_IHDR_SKIP: begin
				if (skip_dec == 32'd0) begin
					phase_mid = PH_IHDR_CRC;
				end
			end
			PH_IHDR_CRC: begin
				if (crc_done) begin
					phase_mid = PH_SEARCH;
				end
			end
			PH_SEARCH: begin
				if (idat_match) begin
					phase_mid = (win[63:32] != 32'd0) ? PH_IDAT_SKIP : PH_IDAT_CRC;
				end
			end
			PH_IDAT_SKIP: begin
				if (skip_dec == 32'd0) begin
					phase_mid = PH_IDAT_CRC;
				end
			end
			PH_IDAT_CRC: begin
				if (crc_done) begin
					phase_mid = PH_SEARCH;
				end
			end
			PH_FAILED: begin
				phase_mid = PH_FAILED;
			end
			default: begin
				phase_mid = PH_FAILED;
			end
		endcase
		phase_d = item.end_of_file ? PH_SIG : phase_mid;
	end

	// Result items for this byte.
	always_comb begin
		emit = '0;
		unique case (phase_q)
			PH_SIG: begin
				if (at_sig_end) begin
					emit.valid0        = take;
					emit.r0.event_kind = sig_match ? EV_SIG_OK : EV_SIG_BAD;
				end
			end
			PH_IHDR: begin
				if (at_ihdr_end) begin
					emit.valid0        = take;
					emit.r0.event_kind = ihdr_match ? EV_IHDR_OK : EV_IHDR_MISSING;
				end
			end
			PH_IDAT_CRC: begin
				if (crc_done) begin
					emit.valid0          = take;
					emit.r0.event_kind   = EV_IDAT;
					emit.r0.chunk_offset = foff_q;
					emit.r0.chunk_length = flen_q;
					emit.r0.chunk_crc    = crc_shift;
				end
			end
			default: begin
				emit.valid0 = 1'b0;
			end
		endcase
		if (item.end_of_file && phase_mid != PH_FAILED) begin
			emit.valid1 = take;
			unique case (phase_mid)
				PH_SIG:  emit.r1.event_kind = EV_SIG_BAD;
				PH_IHDR: emit.r1.event_kind = EV_IHDR_MISSING;
				default: begin
					emit.r1.event_kind = (win[63:32] == NAME_IEND) ? EV_IEND_OK
						: EV_IEND_MISSING;
				end
			endcase
		end
		emit.r0.last_of_run = !emit.valid1;
		emit.r1.last_of_run = 1'b1;
	end

	// Counters and captured chunk fields.
	always_comb begin
		pos_d  = pos_q + OFFSET_BITS'(1);
		skip_d = skip_q;
		cnt_d  = cnt_q;
		foff_d = foff_q;
		flen_d = flen_q;
		crc_d  = crc_q;
		case (phase_q)
			PH_IHDR: begin
				if (at_ihdr_end && ihdr_match) begin
					skip_d = win[63:32];
					cnt_d  = 3'd0;
				end
			end
			PH_IHDR_SKIP, PH_IDAT_SKIP: begin
				skip_d = skip_dec;
				if (skip_dec == 32'd0) begin
					cnt_d = 3'd0;
					crc_d = 32'd0;
				end
			end
			PH_IHDR_CRC: begin
				cnt_d = crc_done ? 3'd0 : cnt_inc;
			end
			PH_SEARCH: begin
				cnt_d = cnt_srch;
				if (idat_match) begin
					foff_d = 32'(off_full);
					flen_d = win[63:32];
					skip_d = win[63:32];
					cnt_d  = 3'd0;
					crc_d  = 32'd0;
				end
			end
			PH_IDAT_CRC: begin
				crc_d = crc_shift;
				cnt_d = crc_done ? 3'd0 : cnt_inc;
			end
			default: begin
				cnt_d = cnt_q;
			end
		endcase
		if (item.end_of_file) begin
			pos_d  = '0;
			skip_d = '0;
			cnt_d  = '0;
			foff_d = '0;
			flen_d = '0;
			crc_d  = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_SIG;
			pos_q    <= '0;
			cnt_q    <= '0;
			recent_q <= '0;
		end else if (take) begin
			phase_q  <= phase_d;
			pos_q    <= pos_d;
			cnt_q    <= cnt_d;
			recent_q <= item.end_of_file ? 64'd0 : win;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			skip_q <= skip_d;
			foff_q <= foff_d;
			flen_q <= flen_d;
			crc_q  <= crc_d;
		end
	end

	a_failed_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		take && phase_q == PH_FAILED |-> !emit.valid0 && !emit.valid1)
		else $error("result produced after a structural failure");

	a_eof_restart: assert property (@(posedge clk) disable iff (!arst_n)
		take && item.end_of_file |=> phase_q == PH_SIG && pos_q == '0)
		else $error("scanner did not restart after the last byte");

	a_search_count: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= WORD_BYTES)
		else $error("window count out of range");

endmodule

[design/pcs_rqueue.sv]
module pcs_rqueue import pcs_pkg::*; #(
	parameter int DEPTH = RQ_DEPTH
) (
	input  logic      clk,
	input  logic      arst_n,
	input  pcs_emit_t emit,
	output logic      room,
	output logic      valid,
	input  logic      stall,
	output out_item_t head
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
	endfunction

	out_item_t     mem_q [DEPTH];
	logic [PW-1:0] wr_q, rd_q, wr_nxt;
	logic [CW-1:0] count_q, push_n;
	logic          pop;

	assign push_n = CW'(emit.valid0) + CW'(emit.valid1);
	assign pop    = valid && !stall;
	assign valid  = count_q != '0;
	assign head   = mem_q[rd_q];
	assign room   = count_q <= CW'(DEPTH - 2);
	assign wr_nxt = next_ptr(wr_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			count_q <= count_q + push_n - CW'(pop);
			if (pop) begin
				rd_q <= next_ptr(rd_q);
			end
			if (emit.valid0 && emit.valid1) begin
				wr_q <= next_ptr(wr_nxt);
			end else if (emit.valid0 || emit.valid1) begin
				wr_q <= wr_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit.valid0) begin
			mem_q[wr_q] <= emit.r0;
			if (emit.valid1) begin
				mem_q[wr_nxt] <= emit.r1;
			end
		end else if (emit.valid1) begin
			mem_q[wr_q] <= emit.r1;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(emit.valid0 || emit.valid1) |-> count_q <= CW'(DEPTH - 2))
		else $error("results written without room for two");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("result queue count exceeds depth");

endmodule

[design/png_chunk_scanner_top.sv]
// PNG chunk scanner. Bytes of a PNG file arrive on the byte channel
// (byte_valid, byte_stall, byte_data), one per transfer, with end_of_file set
// on the final byte. Events leave on the result channel (result_valid,
// result_stall, result_data): signature check, IHDR check, one event per
// complete IDAT chunk with its offset, length and CRC, and the IEND check at
// the last byte. last_of_run marks the final result caused by one byte.
// Throughput is one byte per cycle while the byte channel does not stall. A
// byte is held in an input register and then decoded in a single pass into
// a four-entry result queue, so its first result is offered once the byte
// has passed through both. A byte that gives two results offers them one
// after the other; the queue absorbs this and the byte channel stalls only
// while fewer than two queue entries are free. When the receiver stalls,
// the queue head holds steady and the byte channel keeps taking bytes until
// fewer than two queue entries are free. Reset empties the queue and puts
// the scanner back to the signature check at byte position zero; the last
// byte of every file restarts the scanner likewise as its results are queued.
module png_chunk_scanner_top import pcs_pkg::*; #(
	parameter int OFFSET_BITS = OFFSET_BITS_DEFAULT
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      byte_valid,
	output logic      byte_stall,
	input  in_item_t  byte_data,
	output logic      result_valid,
	input  logic      result_stall,
	output out_item_t result_data
);

	logic      s1_valid_q;
	in_item_t  item_s1;
	logic      room;
	logic      take;
	pcs_emit_t emit;

	// The staged byte is decoded once the queue can take two results.
	assign take       = s1_valid_q && room;
	assign byte_stall = s1_valid_q && !room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (!byte_stall) begin
			s1_valid_q <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_valid && !byte_stall) begin
			item_s1 <= byte_data;
		end
	end

	pcs_parser #(
		.OFFSET_BITS(OFFSET_BITS)
	) u_parser (
		.clk   (clk),
		.arst_n(arst_n),
		.take  (take),
		.item  (item_s1),
		.emit  (emit)
	);

	pcs_rqueue #(
		.DEPTH(RQ_DEPTH)
	) u_rqueue (
		.clk   (clk),
		.arst_n(arst_n),
		.emit  (emit),
		.room  (room),
		.valid (result_valid),
		.stall (result_stall),
		.head  (result_data)
	);

endmodule

[verif/testbench.sv]
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import pcs_pkg::*;

	// A run that reaches this long is considered hung. The limit leaves room for
	// the slowest correct run: every byte waiting out the longest sender gap, and
	// two results per byte each waiting out the longest stall.
	localparam int CYCLE_LIMIT  = 1_000_000;
	// Bytes of random files to send after the directed tests.
	localparam int RANDOM_BYTES = 1300;
	// Cycles to keep watching once nothing is expected. A result leaves the block
	// once its byte has passed the input register and the queue, so this is plenty.
	localparam int DRAIN_CYCLES = 12;
	// Long receiver hold-off for the backpressure test.
	localparam int LONG_HOLD    = 400;
	// Name of an ancillary chunk that the scanner must step over.
	localparam logic [31:0] NAME_TEXT = 32'h74455874;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      byte_valid = 1'b0;
	logic      byte_stall;
	in_item_t  byte_data = '0;
	logic      result_valid;
	logic      result_stall = 1'b0;
	out_item_t result_data;

	png_chunk_scanner_top dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.byte_valid  (byte_valid),
		.byte_stall  (byte_stall),
		.byte_data   (byte_data),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result_data (result_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Results that the scanner owes us, oldest first.
	out_item_t expected_events[$];
	// Bytes of the file being assembled by the stimulus helpers.
	logic [7:0] file_bytes[$];

	int mismatches = 0;
	int cycle_count = 0;
	// Percentage of cycles in which each side starts a gap; zero means both
	// sides run at full rate.
	int idle_pct = 0;
	// Set by a test to ask the receiver for one long hold-off.
	int long_hold_cycles = 0;

	// Our own copy of the scanner state.
	logic [31:0] scan_pos;
	phase_t      scan_phase;
	logic [63:0] tail_bytes;
	logic [31:0] bytes_to_skip;
	logic [2:0]  word_count;
	logic [31:0] idat_offset;
	logic [31:0] idat_length;
	logic [31:0] idat_crc;

	function automatic void restart_scan();
		scan_pos      = '0;
		scan_phase    = PH_SIG;
		tail_bytes    = '0;
		bytes_to_skip = '0;
		word_count    = '0;
		idat_offset   = '0;
		idat_length   = '0;
		idat_crc      = '0;
	endfunction

	function automatic out_item_t make_event(logic [2:0] kind, logic [31:0] off,
			logic [31:0] len, logic [31:0] crc);
		out_item_t ev;
		ev.event_kind   = kind;
		ev.chunk_offset = off;
		ev.chunk_length = len;
		ev.chunk_crc    = crc;
		ev.last_of_run  = 1'b0;
		return ev;
	endfunction

	// Advances the scanner copy by one transferred byte and queues the
	// events that byte must produce.
	function automatic void scan_png_byte(input in_item_t it);
		out_item_t   produced[2];
		int          n;
		logic [31:0] pos;
		n = 0;
		pos = scan_pos;
		tail_bytes = {tail_bytes[55:0], it.data_byte};

		case (scan_phase)
			PH_SIG: begin
				if (pos == SIG_LAST_POS) begin
					if (tail_bytes == SIG_WORD) begin
						produced[n] = make_event(EV_SIG_OK, 0, 0, 0);
						n++;
						scan_phase = PH_IHDR;
					end else begin
						produced[n] = make_event(EV_SIG_BAD, 0, 0, 0);
						n++;
						scan_phase = PH_FAILED;
					end
				end
			end
			PH_IHDR: begin
				if (pos == IHDR_LAST_POS) begin
					if (tail_bytes[31:0] == NAME_IHDR) begin
						produced[n] = make_event(EV_IHDR_OK, 0, 0, 0);
						n++;
						bytes_to_skip = tail_bytes[63:32];
						word_count = '0;
						scan_phase = (bytes_to_skip != 0) ? PH_IHDR_SKIP : PH_IHDR_CRC;
					end else begin
						produced[n] = make_event(EV_IHDR_MISSING, 0, 0, 0);
						n++;
						scan_phase = PH_FAILED;
					end
				end
			end
			PH_IHDR_SKIP: begin
				bytes_to_skip = bytes_to_skip - 1;
				if (bytes_to_skip == 0) begin
					word_count = '0;
					scan_phase = PH_IHDR_CRC;
				end
			end
			PH_IHDR_CRC: begin
				word_count = word_count + 1;
				if (word_count >= WORD_BYTES) begin
					word_count = '0;
					scan_phase = PH_SEARCH;
				end
			end
			PH_SEARCH: begin
				// The window only counts once all four name bytes came after
				// the point where the search started.
				if (word_count < WORD_BYTES)
					word_count = word_count + 1;
				if (word_count >= WORD_BYTES && tail_bytes[31:0] == NAME_IDAT) begin
					idat_offset   = pos - NAME_TO_LEN;
					idat_length   = tail_bytes[63:32];
					bytes_to_skip = idat_length;
					word_count    = '0;
					idat_crc      = '0;
					scan_phase = (bytes_to_skip != 0) ? PH_IDAT_SKIP : PH_IDAT_CRC;
				end
			end
			PH_IDAT_SKIP: begin
				bytes_to_skip = bytes_to_skip - 1;
				if (bytes_to_skip == 0) begin
					word_count = '0;
					idat_crc   = '0;
					scan_phase = PH_IDAT_CRC;
				end
			end
			PH_IDAT_CRC: begin
				idat_crc = {idat_crc[23:0], it.data_byte};
				word_count = word_count + 1;
				if (word_count >= WORD_BYTES) begin
					produced[n] = make_event(EV_IDAT, idat_offset, idat_length, idat_crc);
					n++;
					word_count = '0;
					scan_phase = PH_SEARCH;
				end
			end
			default: begin
			end
		endcase

		scan_pos = scan_pos + 1;

		if (it.end_of_file) begin
			if (scan_phase == PH_SIG) begin
				produced[n] = make_event(EV_SIG_BAD, 0, 0, 0);
				n++;
			end else if (scan_phase == PH_IHDR) begin
				produced[n] = make_event(EV_IHDR_MISSING, 0, 0, 0);
				n++;
			end else if (scan_phase != PH_FAILED) begin
				produced[n] = make_event((tail_bytes[63:32] == NAME_IEND) ?
					EV_IEND_OK : EV_IEND_MISSING, 0, 0, 0);
				n++;
			end
			restart_scan();
		end

		if (n > 0)
			produced[n - 1].last_of_run = 1'b1;
		for (int i = 0; i < n; i++)
			expected_events.push_back(produced[i]);
	endfunction

	// Gap length for either side: mostly none, sometimes short, rarely long.
	function automatic int pick_gap();
		if (idle_pct == 0 || $urandom_range(0, 99) >= idle_pct)
			return 0;
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(10, 40);
		return $urandom_range(1, 3);
	endfunction

	// Offers one byte and returns at the clock edge of its transfer. The
	// handshake is judged at the falling edge, where stall and valid have
	// settled, and the transfer happens at the following rising edge.
	task automatic send_byte(input in_item_t it);
		int  gap;
		bit  taken;
		gap = pick_gap();
		if (gap > 0) begin
			byte_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		byte_valid <= 1'b1;
		byte_data  <= it;
		do begin
			@(negedge clk);
			taken = !byte_stall;
			@(posedge clk);
		end while (!taken);
		scan_png_byte(it);
	endtask

	// Sends the assembled file, flagging its last byte as the end of file.
	task automatic send_file();
		in_item_t it;
		for (int i = 0; i < file_bytes.size(); i++) begin
			it.data_byte   = file_bytes[i];
			it.end_of_file = (i == file_bytes.size() - 1);
			send_byte(it);
		end
		file_bytes.delete();
	endtask

	// The sender goes quiet until every owed result has arrived.
	task automatic wait_drained();
		byte_valid <= 1'b0;
		while (expected_events.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic void add_word(logic [31:0] w);
		for (int i = 3; i >= 0; i--)
			file_bytes.push_back(w[8 * i +: 8]);
	endfunction

	function automatic void add_random(int count);
		for (int i = 0; i < count; i++)
			file_bytes.push_back(8'($urandom));
	endfunction

	function automatic void add_signature();
		add_word(SIG_WORD[63:32]);
		add_word(SIG_WORD[31:0]);
	endfunction

	// Length, name, payload and CRC of one chunk; payload and CRC are random.
	function automatic void add_chunk(logic [31:0] name, logic [31:0] len);
		add_word(len);
		add_word(name);
		add_random(len);
		add_random(4);
	endfunction

	// A file with random content: signature, IHDR, up to four chunks or runs of
	// loose bytes, and usually a closing IEND.
	function automatic void build_png();
		int chunks;
		add_signature();
		add_chunk(NAME_IHDR, $urandom_range(0, 13));
		chunks = $urandom_range(0, 4);
		repeat (chunks) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4, 5: begin
					add_chunk(NAME_IDAT, ($urandom_range(0, 9) == 0) ?
						$urandom_range(21, 120) : $urandom_range(0, 20));
				end
				6, 7: begin
					add_chunk($urandom(), $urandom_range(0, 12));
				end
				default: begin
					add_random($urandom_range(1, 6));
				end
			endcase
		end
		if ($urandom_range(0, 4) != 0)
			add_chunk(NAME_IEND, 0);
	endfunction

	// Signature check: files that end before, at and after the last
	// signature byte, and a broken signature that silences the rest.
	task automatic test_signature();
		idle_pct = 20;
		file_bytes.push_back(8'h89);
		send_file();
		add_random(4);
		send_file();
		// Ending on the last signature byte gives sig ok and then ihdr missing.
		add_signature();
		send_file();
		add_signature();
		file_bytes[3] = 8'h46;
		add_random(5);
		send_file();
		wait_drained();
	endtask

	// IHDR header: a wrong name, a file ending inside the header, a file
	// ending on the last name byte, and the largest IHDR length cut short.
	task automatic test_ihdr();
		add_signature();
		add_word(32'd13);
		add_word(32'h49484458);
		add_random(3);
		send_file();
		add_signature();
		add_word(32'd13);
		send_file();
		add_signature();
		add_word(32'd0);
		add_word(NAME_IHDR);
		send_file();
		// The skip never finishes, yet the IEND check at the end still holds.
		add_signature();
		add_word(32'hFFFF_FFFF);
		add_word(NAME_IHDR);
		add_random(6);
		add_chunk(NAME_IEND, 0);
		send_file();
		wait_drained();
	endtask

	// IDAT search: a name that straddles the start of the search, empty and
	// short chunks, a chunk whose last CRC byte ends the file, and a chunk
	// too long to finish before the IEND.
	task automatic test_idat();
		add_signature();
		add_word(32'd0);
		add_word(NAME_IHDR);
		// The IHDR CRC ends in "IDA"; the "T" that follows must not match.
		file_bytes.push_back(8'h00);
		file_bytes.push_back(8'h49);
		file_bytes.push_back(8'h44);
		file_bytes.push_back(8'h41);
		file_bytes.push_back(8'h54);
		add_chunk(NAME_IDAT, 0);
		add_chunk(NAME_TEXT, 3);
		add_chunk(NAME_IDAT, 5);
		add_chunk(NAME_IDAT, 0);
		send_file();
		add_signature();
		add_chunk(NAME_IHDR, 13);
		add_word(32'hFFFF_FFFF);
		add_word(NAME_IDAT);
		add_random(3);
		add_chunk(NAME_IEND, 0);
		send_file();
		add_signature();
		add_chunk(NAME_IHDR, 13);
		add_chunk(NAME_IDAT, 1);
		add_chunk(NAME_IEND, 0);
		send_file();
		wait_drained();
	endtask

	// The receiver holds off for a long stretch while one-byte files, each
	// worth a sig bad result, stream in at full rate. The result queue fills
	// and the byte channel must stall without losing anything.
	task automatic test_backpressure();
		idle_pct = 0;
		long_hold_cycles = LONG_HOLD;
		for (int i = 0; i < 30; i++) begin
			add_random(1);
			send_file();
		end
		add_signature();
		add_chunk(NAME_IHDR, 0);
		for (int i = 0; i < 6; i++)
			add_chunk(NAME_IDAT, 0);
		add_chunk(NAME_IEND, 0);
		send_file();
		wait_drained();
	endtask

	// Mostly well-formed files with random content, plus truncated files,
	// files with one byte corrupted, and plain noise.
	task automatic test_random_files();
		int sent;
		int kind;
		int cut;
		sent = 0;
		while (sent < RANDOM_BYTES) begin
			idle_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 50);
			kind = $urandom_range(0, 99);
			if (kind < 95)
				build_png();
			else
				add_random($urandom_range(1, 40));
			if (kind >= 70 && kind < 85) begin
				cut = $urandom_range(1, file_bytes.size());
				while (file_bytes.size() > cut)
					void'(file_bytes.pop_back());
			end else if (kind >= 85 && kind < 95) begin
				file_bytes[$urandom_range(0, file_bytes.size() - 1)] = 8'($urandom);
			end
			sent += file_bytes.size();
			send_file();
			if ($urandom_range(0, 19) == 0)
				wait_drained();
		end
	endtask

	// Receiver: random stalls, or one long hold-off when a test asks for it.
	// Each stall is counted out here, one rising edge at a time.
	initial begin : result_receiver
		int hold;
		forever begin
			@(posedge clk);
			if (long_hold_cycles > 0) begin
				hold = long_hold_cycles;
				long_hold_cycles = 0;
			end else begin
				hold = pick_gap();
			end
			if (hold > 0) begin
				result_stall <= 1'b1;
				repeat (hold) @(posedge clk);
				result_stall <= 1'b0;
			end
		end
	end

	function automatic void compare_field(string field, logic [31:0] want,
			logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
			mismatches++;
		end
	endfunction

	// Every result transfer is matched against the oldest owed result. As
	// with the byte channel, the handshake is judged at the falling edge.
	always @(negedge clk) begin : result_check
		out_item_t want;
		if (arst_n && result_valid === 1'b1 && result_stall == 1'b0) begin
			if (expected_events.size() == 0) begin
				$display("%0t: result with none expected, expected nothing, actual %p",
					$time, result_data);
				mismatches++;
			end else begin
				want = expected_events.pop_front();
				compare_field("event_kind", want.event_kind, result_data.event_kind);
				compare_field("chunk_offset", want.chunk_offset, result_data.chunk_offset);
				compare_field("chunk_length", want.chunk_length, result_data.chunk_length);
				compare_field("chunk_crc", want.chunk_crc, result_data.chunk_crc);
				compare_field("last_of_run", want.last_of_run, result_data.last_of_run);
			end
		end
	end

	// A hung handshake ends the run here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		restart_scan();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_signature();
		test_ihdr();
		test_idat();
		test_backpressure();
		test_random_files();

		// All bytes are in; let the last results come out, then watch a
		// little longer for anything extra.
		wait_drained();
		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

[sim.f]
design/pcs_pkg.sv
design/pcs_parser.sv
design/pcs_rqueue.sv
design/png_chunk_scanner_top.sv
verif/testbench.sv
